### hdl/erg_pkg.sv
// Shared constants, register codes and the divider-cell link type
// for the euclidean rhythm gate. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package erg_pkg;

    localparam int PHASE_BITS = 16;
    localparam int MAX_STEPS  = 64;
    localparam int IDX_W      = $clog2(MAX_STEPS);
    localparam int REM_W      = 7;
    localparam int NUM_W      = 6;
    localparam int MULT_W     = 4;
    localparam int DVD_W      = NUM_W + PHASE_BITS;
    localparam int QUO_W      = PHASE_BITS;
    localparam int AUX_W      = 2 * PHASE_BITS;
    localparam int OFF_CELLS  = DVD_W;
    localparam int MOD_CELLS  = IDX_W;
    localparam int PROD_W     = IDX_W + REM_W;
    localparam int FI_W       = PHASE_BITS + REM_W;
    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 5;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ENABLE      = 3'd0,
        REG_STEPS       = 3'd1,
        REG_PULSES      = 3'd2,
        REG_OFFSET_NUM  = 3'd3,
        REG_OFFSET_DEN  = 3'd4,
        REG_PHASE_MULT  = 3'd5,
        REG_PULSE_WIDTH = 3'd6
    } t_reg_idx;

    // One restoring-division step travels through the chain as this record.
    typedef struct packed {
        logic             valid;
        logic [REM_W-1:0] rem;
        logic [DVD_W-1:0] dvd;
        logic [QUO_W-1:0] quo;
        logic [AUX_W-1:0] aux;
    } t_div_link;

endpackage

`default_nettype wire

### hdl/erg_if.sv
// Valid/ready channel interfaces for phase samples in and gate results out.
// Depends on erg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface erg_in_if;
    logic                            valid;
    logic                            ready;
    logic [erg_pkg::PHASE_BITS-1:0]  phase;

    modport source (output valid, output phase, input ready);
    modport sink   (input valid, input phase, output ready);
endinterface

interface erg_out_if;
    logic                            valid;
    logic                            ready;
    logic                            gate;
    logic [erg_pkg::IDX_W-1:0]       step_index;
    logic [erg_pkg::PHASE_BITS-1:0]  wrapped_phase;

    modport source (output valid, output gate, output step_index, output wrapped_phase,
                    input ready);
    modport sink   (input valid, input gate, input step_index, input wrapped_phase,
                    output ready);
endinterface

`default_nettype wire

### hdl/euclidean_rhythm_gate_top.sv
// Top level of the euclidean rhythm gate: APB register file, offset divider
// chain, scale stages, modulo chain and output register.
// Depends on erg_pkg, erg_if, erg_div_cell and erg_scale.
`timescale 1ns / 1ps
`default_nettype none

// Takes one Q0.16 phase sample per transfer and returns one result per sample
// (gate, step_index, wrapped_phase), in order. Throughput is one sample per
// clock unless the output stalls; the stages are 22 cells of the offset divider
// chain, which works out floor(num*65536/den) one quotient bit per cell,
// three scale stages, six cells of the (i*k) mod n chain and the output
// register. Every stage only holds when the one after it is full and stalled,
// so samples keep flowing while a result waits at the output. Registers sit at
// byte address 4*i (enable, steps, pulses, offset_num, offset_den, phase_mult,
// pulse_width); write them only while no sample is in flight.
module euclidean_rhythm_gate_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    erg_in_if.sink                             i_in,
    erg_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [erg_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [erg_pkg::DATA_W-1:0]    pwdata,
    output logic      [erg_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    logic                              r_enable;
    logic [erg_pkg::REM_W-1:0]         r_steps;
    logic [erg_pkg::REM_W-1:0]         r_pulses;
    logic [erg_pkg::NUM_W-1:0]         r_offset_num;
    logic [erg_pkg::REM_W-1:0]         r_offset_den;
    logic [erg_pkg::MULT_W-1:0]        r_phase_mult;
    logic [erg_pkg::PHASE_BITS-1:0]    r_pulse_width;

    logic                              w_wr;
    erg_pkg::t_reg_idx                 w_idx;
    logic [erg_pkg::REM_W-1:0]         w_n;
    logic [erg_pkg::REM_W-1:0]         w_k;
    logic [erg_pkg::REM_W-1:0]         w_den;
    logic [erg_pkg::MULT_W-1:0]        w_mult;
    logic [erg_pkg::PHASE_BITS+erg_pkg::MULT_W-1:0] w_pm;

    erg_pkg::t_div_link                off_link [erg_pkg::OFF_CELLS+1];
    logic                              off_adv  [erg_pkg::OFF_CELLS+1];
    erg_pkg::t_div_link                mod_link [erg_pkg::MOD_CELLS+1];
    logic                              mod_adv  [erg_pkg::MOD_CELLS+1];

    logic                              r_out_valid;
    logic                              r_out_gate;
    logic [erg_pkg::IDX_W-1:0]         r_out_idx;
    logic [erg_pkg::PHASE_BITS-1:0]    r_out_phase;
    logic                              w_out_adv;
    logic [erg_pkg::IDX_W-1:0]         w_idx_val;
    logic [erg_pkg::PHASE_BITS-1:0]    w_frac;
    logic [erg_pkg::PHASE_BITS-1:0]    w_wrapped;
    logic                              w_gate;

    // ---------------- register file ----------------
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = erg_pkg::t_reg_idx'(paddr[erg_pkg::PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_steps       <= erg_pkg::REM_W'(1);
            r_pulses      <= erg_pkg::REM_W'(1);
            r_offset_num  <= '0;
            r_offset_den  <= erg_pkg::REM_W'(1);
            r_phase_mult  <= erg_pkg::MULT_W'(1);
            r_pulse_width <= erg_pkg::PHASE_BITS'(32768);
        end else if (w_wr) begin
            case (w_idx)
                erg_pkg::REG_ENABLE:      r_enable      <= pwdata[0];
                erg_pkg::REG_STEPS:       r_steps       <= pwdata[erg_pkg::REM_W-1:0];
                erg_pkg::REG_PULSES:      r_pulses      <= pwdata[erg_pkg::REM_W-1:0];
                erg_pkg::REG_OFFSET_NUM:  r_offset_num  <= pwdata[erg_pkg::NUM_W-1:0];
                erg_pkg::REG_OFFSET_DEN:  r_offset_den  <= pwdata[erg_pkg::REM_W-1:0];
                erg_pkg::REG_PHASE_MULT:  r_phase_mult  <= pwdata[erg_pkg::MULT_W-1:0];
                erg_pkg::REG_PULSE_WIDTH: r_pulse_width <= pwdata[erg_pkg::PHASE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            erg_pkg::REG_ENABLE:      prdata = erg_pkg::DATA_W'(r_enable);
            erg_pkg::REG_STEPS:       prdata = erg_pkg::DATA_W'(r_steps);
            erg_pkg::REG_PULSES:      prdata = erg_pkg::DATA_W'(r_pulses);
            erg_pkg::REG_OFFSET_NUM:  prdata = erg_pkg::DATA_W'(r_offset_num);
            erg_pkg::REG_OFFSET_DEN:  prdata = erg_pkg::DATA_W'(r_offset_den);
            erg_pkg::REG_PHASE_MULT:  prdata = erg_pkg::DATA_W'(r_phase_mult);
            erg_pkg::REG_PULSE_WIDTH: prdata = erg_pkg::DATA_W'(r_pulse_width);
            default:                  prdata = '0;
        endcase
    end

    // clamp the register values into their legal ranges
    always_comb begin
        if (r_steps == '0) begin
            w_n = erg_pkg::REM_W'(1);
        end else if (r_steps > erg_pkg::REM_W'(erg_pkg::MAX_STEPS)) begin
            w_n = erg_pkg::REM_W'(erg_pkg::MAX_STEPS);
        end else begin
            w_n = r_steps;
        end
        if (r_pulses == '0) begin
            w_k = erg_pkg::REM_W'(1);
        end else if (r_pulses > w_n) begin
            w_k = w_n;
        end else begin
            w_k = r_pulses;
        end
        w_den  = (r_offset_den == '0) ? erg_pkg::REM_W'(1) : r_offset_den;
        w_mult = (r_phase_mult == '0) ? erg_pkg::MULT_W'(1) : r_phase_mult;
    end

    // ---------------- offset divider chain ----------------
    // Divide {num, 16 zeros} by den; the low quotient bits are the offset,
    // which also takes care of reducing num modulo den.
    assign w_pm = (erg_pkg::PHASE_BITS+erg_pkg::MULT_W)'(i_in.phase)
                * (erg_pkg::PHASE_BITS+erg_pkg::MULT_W)'(w_mult);

    always_comb begin
        off_link[0].valid = i_in.valid;
        off_link[0].rem   = '0;
        off_link[0].dvd   = {r_offset_num, {erg_pkg::PHASE_BITS{1'b0}}};
        off_link[0].quo   = '0;
        off_link[0].aux   = erg_pkg::AUX_W'(w_pm[erg_pkg::PHASE_BITS-1:0]);
    end

    assign i_in.ready = off_adv[0];

    for (genvar g = 0; g < erg_pkg::OFF_CELLS; g++) begin : g_off
        erg_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_divisor (w_den),
            .i_link    (off_link[g]),
            .i_adv     (off_adv[g+1]),
            .o_link    (off_link[g+1]),
            .o_adv     (off_adv[g])
        );
    end

    // ---------------- wrap, scale and pulse multiply ----------------
    erg_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_steps  (w_n),
        .i_pulses (w_k),
        .i_link   (off_link[erg_pkg::OFF_CELLS]),
        .i_adv    (mod_adv[0]),
        .o_link   (mod_link[0]),
        .o_adv    (off_adv[erg_pkg::OFF_CELLS])
    );

    // ---------------- (i*k) mod n chain ----------------
    for (genvar g = 0; g < erg_pkg::MOD_CELLS; g++) begin : g_mod
        erg_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_divisor (w_n),
            .i_link    (mod_link[g]),
            .i_adv     (mod_adv[g+1]),
            .o_link    (mod_link[g+1]),
            .o_adv     (mod_adv[g])
        );
    end

    // ---------------- output register ----------------
    assign w_out_adv                 = !r_out_valid || o_out.ready;
    assign mod_adv[erg_pkg::MOD_CELLS] = w_out_adv;

    always_comb begin
        w_idx_val = mod_link[erg_pkg::MOD_CELLS].rem[erg_pkg::IDX_W-1:0];
        w_frac    = mod_link[erg_pkg::MOD_CELLS].aux[erg_pkg::PHASE_BITS-1:0];
        w_wrapped = mod_link[erg_pkg::MOD_CELLS].aux[erg_pkg::PHASE_BITS +: erg_pkg::PHASE_BITS];
        w_gate    = ({1'b0, w_idx_val} < w_k) && (w_frac < r_pulse_width);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= mod_link[erg_pkg::MOD_CELLS].valid;
        end
    end

    // drop everything to zero while disabled
    always_ff @(posedge i_clk) begin
        if (w_out_adv) begin
            r_out_gate  <= r_enable && w_gate;
            r_out_idx   <= r_enable ? w_idx_val : '0;
            r_out_phase <= r_enable ? w_wrapped : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.gate          = r_out_gate;
    assign o_out.step_index    = r_out_idx;
    assign o_out.wrapped_phase = r_out_phase;

endmodule

`default_nettype wire

### hdl/erg_div_cell.sv
// One registered restoring-division step: shift in a dividend bit, compare
// and subtract, shift a quotient bit into quo. Depends on erg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erg_div_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [erg_pkg::REM_W-1:0] i_divisor,
    input  wire erg_pkg::t_div_link        i_link,
    input  wire logic                      i_adv,
    output erg_pkg::t_div_link             o_link,
    output logic                           o_adv
);

    logic                      r_valid;
    erg_pkg::t_div_link        r_data;
    erg_pkg::t_div_link        n_data;
    logic [erg_pkg::REM_W:0]   w_trial;
    logic [erg_pkg::REM_W:0]   w_diff;
    logic                      w_ge;

    assign o_adv = !r_valid || i_adv;

    always_comb begin
        w_trial = {i_link.rem, i_link.dvd[erg_pkg::DVD_W-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        w_ge    = (w_trial >= {1'b0, i_divisor});
        n_data       = i_link;
        n_data.rem   = w_ge ? w_diff[erg_pkg::REM_W-1:0] : w_trial[erg_pkg::REM_W-1:0];
        n_data.dvd   = {i_link.dvd[erg_pkg::DVD_W-2:0], 1'b0};
        n_data.quo   = {i_link.quo[erg_pkg::QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_link.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_data <= n_data;
        end
    end

    always_comb begin
        o_link       = r_data;
        o_link.valid = r_valid;
    end

endmodule

`default_nettype wire

### hdl/erg_scale.sv
// Three pipeline stages between the two divider chains: add the offset and
// wrap, scale by the step count, multiply by the pulse count. Depends on erg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erg_scale (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [erg_pkg::REM_W-1:0] i_steps,
    input  wire logic [erg_pkg::REM_W-1:0] i_pulses,
    input  wire erg_pkg::t_div_link        i_link,
    input  wire logic                      i_adv,
    output erg_pkg::t_div_link             o_link,
    output logic                           o_adv
);

    logic                                r_a_valid;
    logic [erg_pkg::PHASE_BITS-1:0]      r_a_p;
    logic                                r_b_valid;
    logic [erg_pkg::PHASE_BITS-1:0]      r_b_p;
    logic [erg_pkg::PHASE_BITS-1:0]      r_b_frac;
    logic [erg_pkg::IDX_W-1:0]           r_b_i;
    logic                                r_c_valid;
    erg_pkg::t_div_link                  r_c_data;
    logic                                w_a_adv;
    logic                                w_b_adv;
    logic                                w_c_adv;
    logic [erg_pkg::FI_W-1:0]            w_fi;
    logic [erg_pkg::PROD_W-1:0]          w_prod;

    assign w_c_adv = !r_c_valid || i_adv;
    assign w_b_adv = !r_b_valid || w_c_adv;
    assign w_a_adv = !r_a_valid || w_b_adv;
    assign o_adv   = w_a_adv;

    // i stays below the step count because the wrapped phase is below one
    assign w_fi   = erg_pkg::FI_W'(r_a_p) * erg_pkg::FI_W'(i_steps);
    assign w_prod = erg_pkg::PROD_W'(r_b_i) * erg_pkg::PROD_W'(i_pulses);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_a_adv) r_a_valid <= i_link.valid;
            if (w_b_adv) r_b_valid <= r_a_valid;
            if (w_c_adv) r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_adv) begin
            r_a_p <= i_link.aux[erg_pkg::PHASE_BITS-1:0] + i_link.quo;
        end
        if (w_b_adv) begin
            r_b_p    <= r_a_p;
            r_b_frac <= w_fi[erg_pkg::PHASE_BITS-1:0];
            r_b_i    <= w_fi[erg_pkg::PHASE_BITS +: erg_pkg::IDX_W];
        end
        if (w_c_adv) begin
            // seed the modulo chain: upper product bits are already below n
            r_c_data.valid <= 1'b1;
            r_c_data.rem   <= w_prod[erg_pkg::IDX_W +: erg_pkg::REM_W];
            r_c_data.dvd   <= {w_prod[erg_pkg::IDX_W-1:0],
                               {(erg_pkg::DVD_W-erg_pkg::IDX_W){1'b0}}};
            r_c_data.quo   <= '0;
            r_c_data.aux   <= {r_b_p, r_b_frac};
        end
    end

    always_comb begin
        o_link       = r_c_data;
        o_link.valid = r_c_valid;
    end

endmodule

`default_nettype wire

### tb/sv/euclidean_rhythm_gate_top_test.sv
// Self-checking testbench for euclidean_rhythm_gate_top: feeds phase samples
// over the input channel, predicts each gate result and checks them in order.
// Depends on erg_pkg, erg_if and the RTL under hdl/.
`timescale 1ns / 1ps

module euclidean_rhythm_gate_top_test;
    import erg_pkg::*;

    localparam int          CLK_HALF     = 6;
    localparam int          RESET_CYCLES = 7;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          LONG_HOLD    = 400;
    localparam int          RAND_PHASES  = 14;
    localparam int          RAND_ITEMS   = 100;
    localparam int          TAIL_ITEMS   = 50;
    localparam int          HOLD_PHASE   = 2;
    localparam int          PRINT_CAP    = 40;
    localparam longint      LIMIT_NS     = 64'd7_200_000;
    localparam int unsigned PH_MASK      = (1 << PHASE_BITS) - 1;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic                  gate;
        logic [IDX_W-1:0]      step_index;
        logic [PHASE_BITS-1:0] wrapped_phase;
    } gate_result_t;

    typedef struct {
        bit        enable;
        bit [6:0]  steps;
        bit [6:0]  pulses;
        bit [5:0]  offset_num;
        bit [6:0]  offset_den;
        bit [3:0]  phase_mult;
        bit [15:0] pulse_width;
    } gate_cfg_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    erg_in_if  phase_if ();
    erg_out_if gate_if ();

    euclidean_rhythm_gate_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (phase_if),
        .o_out   (gate_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gate_cfg_t                 cfg;
    logic [PHASE_BITS-1:0]     pending_phases[$];
    gate_result_t              expected_gates[$];
    int unsigned               items_sent;
    int unsigned               results_seen;
    int unsigned               mismatches;
    int unsigned               cfg_phases;
    int unsigned               tx_gap;
    int unsigned               rx_gap;
    int unsigned               hold_count;
    bit                        idle_off;
    bit                        hold_request;
    bit                        hold_done;
    logic                      rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Expected result of one phase sample under the given register contents.
    function automatic gate_result_t rhythm_predict(gate_cfg_t c, logic [PHASE_BITS-1:0] ph);
        int unsigned n, k, den, num, mult, off, p, fi, step, rem, idx;
        gate_result_t r;
        r = '0;
        if (!c.enable) return r;
        n = (c.steps < 1) ? 1 : c.steps;
        if (n > MAX_STEPS) n = MAX_STEPS;
        k = (c.pulses < 1) ? 1 : c.pulses;
        if (k > n) k = n;
        den  = (c.offset_den < 1) ? 1 : c.offset_den;
        num  = c.offset_num % den;
        mult = (c.phase_mult < 1) ? 1 : c.phase_mult;
        off  = (num << PHASE_BITS) / den;
        p    = (ph * mult) & PH_MASK;
        p    = (p + off) & PH_MASK;
        fi   = p * n;
        step = fi >> PHASE_BITS;
        rem  = fi & PH_MASK;
        idx  = (step * k) % n;
        r.gate          = (idx < k) && (rem < c.pulse_width);
        r.step_index    = idx[IDX_W-1:0];
        r.wrapped_phase = p[PHASE_BITS-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH at result %0d: %s got 0x%0h expected 0x%0h",
                     results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE:      cfg.enable      = value[0];
            REG_STEPS:       cfg.steps       = value[6:0];
            REG_PULSES:      cfg.pulses      = value[6:0];
            REG_OFFSET_NUM:  cfg.offset_num  = value[5:0];
            REG_OFFSET_DEN:  cfg.offset_den  = value[6:0];
            REG_PHASE_MULT:  cfg.phase_mult  = value[3:0];
            REG_PULSE_WIDTH: cfg.pulse_width = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_gate_cfg(input gate_cfg_t c);
        reg_write(REG_STEPS,       DATA_W'(c.steps));
        reg_write(REG_PULSES,      DATA_W'(c.pulses));
        reg_write(REG_OFFSET_NUM,  DATA_W'(c.offset_num));
        reg_write(REG_OFFSET_DEN,  DATA_W'(c.offset_den));
        reg_write(REG_PHASE_MULT,  DATA_W'(c.phase_mult));
        reg_write(REG_PULSE_WIDTH, DATA_W'(c.pulse_width));
        reg_write(REG_ENABLE,      DATA_W'(c.enable));
        cfg_phases++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_phases.size() != 0 || expected_gates.size() != 0);
    endtask

    function automatic bit [6:0] pick_count();
        if ($urandom_range(0, 7) == 0) return 7'($urandom());
        return 7'($urandom_range(0, 64));
    endfunction

    function automatic gate_cfg_t random_cfg();
        gate_cfg_t c;
        c.enable     = ($urandom_range(0, 5) != 0);
        c.steps      = pick_count();
        c.pulses     = pick_count();
        c.offset_num = 6'($urandom());
        c.offset_den = pick_count();
        c.phase_mult = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 8));
        case ($urandom_range(0, 7))
            0:       c.pulse_width = 16'h0000;
            1:       c.pulse_width = 16'hFFFF;
            default: c.pulse_width = 16'($urandom());
        endcase
        return c;
    endfunction

    function automatic logic [PHASE_BITS-1:0] pick_phase();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return PHASE_BITS'($urandom_range(0, 3));
            default: return PHASE_BITS'($urandom());
        endcase
    endfunction

    // Sample driver: hold an offered sample until it transfers, idle in bursts.
    always @(posedge i_clk) begin : drive_phase
        if (i_rst_n) begin
            if (phase_if.valid && phase_if.ready) begin
                expected_gates.push_back(rhythm_predict(cfg, pending_phases.pop_front()));
                items_sent++;
            end
            if (phase_if.valid && !phase_if.ready) begin
                phase_if.valid <= 1'b1;
            end else if (tx_gap != 0) begin
                tx_gap--;
                phase_if.valid <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 9) == 0) begin
                tx_gap = $urandom_range(0, 13);
                phase_if.valid <= 1'b0;
            end else if (pending_phases.size() != 0) begin
                phase_if.valid <= 1'b1;
                phase_if.phase <= pending_phases[0];
            end else begin
                phase_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off so the pipeline fills and backs up the input.
    always @(posedge i_clk) begin : long_hold
        if (i_rst_n && hold_request && !hold_done) begin
            if (hold_count == LONG_HOLD) begin
                hold_done = 1'b1;
                rx_hold <= 1'b0;
            end else begin
                hold_count++;
                rx_hold <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_gate
        gate_result_t got;
        gate_result_t want;
        if (i_rst_n) begin
            if (gate_if.valid && gate_if.ready) begin
                got = {gate_if.gate, gate_if.step_index, gate_if.wrapped_phase};
                if (expected_gates.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'(got), 32'(0));
                end else begin
                    want = expected_gates.pop_front();
                    if (got.gate !== want.gate)
                        report_mismatch("gate", 32'(got.gate), 32'(want.gate));
                    if (got.step_index !== want.step_index)
                        report_mismatch("step_index", 32'(got.step_index),
                                        32'(want.step_index));
                    if (got.wrapped_phase !== want.wrapped_phase)
                        report_mismatch("wrapped_phase", 32'(got.wrapped_phase),
                                        32'(want.wrapped_phase));
                end
                results_seen++;
            end
            if (rx_hold) begin
                gate_if.ready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                gate_if.ready <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(0, 13);
                gate_if.ready <= 1'b0;
            end else begin
                gate_if.ready <= 1'b1;
            end
        end
    end

    initial begin : run_sequence
        gate_cfg_t c;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        phase_if.valid = 1'b0;
        phase_if.phase = '0;
        gate_if.ready  = 1'b0;
        rx_hold        = 1'b0;
        idle_off       = 1'b0;
        hold_request   = 1'b0;
        hold_done      = 1'b0;
        hold_count     = 0;
        tx_gap         = 0;
        rx_gap         = 0;
        items_sent     = 0;
        results_seen   = 0;
        mismatches     = 0;
        cfg_phases     = 0;
        cfg = '{enable: 1'b0, steps: 7'd1, pulses: 7'd1, offset_num: 6'd0,
                offset_den: 7'd1, phase_mult: 4'd1, pulse_width: 16'h8000};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset contents: disabled, every result zero.
        pending_phases.push_back(16'h0000);
        pending_phases.push_back(16'hFFFF);
        wait_drained();

        // Plain pattern, phase extremes and the last step.
        load_gate_cfg('{1'b1, 7'd8, 7'd3, 6'd0, 7'd1, 4'd1, 16'h8000});
        pending_phases.push_back(16'h0000);
        pending_phases.push_back(16'h2000);
        pending_phases.push_back(16'h8000);
        pending_phases.push_back(16'hFFFF);
        wait_drained();

        // Steps above the maximum, zero pulses, numerator past denominator,
        // top multiplier, zero pulse width.
        load_gate_cfg('{1'b1, 7'd127, 7'd0, 6'd63, 7'd5, 4'd15, 16'h0000});
        pending_phases.push_back(16'h1234);
        pending_phases.push_back(16'hFFFF);
        pending_phases.push_back(16'h0001);
        wait_drained();

        // Zero steps, denominator and multiplier, pulses above steps; an
        // unmapped register write must change nothing.
        load_gate_cfg('{1'b1, 7'd0, 7'd127, 6'd5, 7'd0, 4'd0, 16'hFFFF});
        reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        pending_phases.push_back(16'h0000);
        pending_phases.push_back(16'h7FFF);
        pending_phases.push_back(16'hFFFF);
        wait_drained();

        load_gate_cfg('{1'b1, 7'd64, 7'd64, 6'd63, 7'd64, 4'd8, 16'h0001});
        pending_phases.push_back(16'hFFFF);
        pending_phases.push_back(16'h0000);
        pending_phases.push_back(16'h5555);
        pending_phases.push_back(16'hAAAA);
        wait_drained();

        load_gate_cfg('{1'b1, 7'd5, 7'd2, 6'd1, 7'd3, 4'd2, 16'hC000});
        pending_phases.push_back(16'h3333);
        pending_phases.push_back(16'h9999);
        pending_phases.push_back(16'hFFFE);
        wait_drained();

        load_gate_cfg('{1'b0, 7'd64, 7'd7, 6'd9, 7'd11, 4'd3, 16'hFFFF});
        pending_phases.push_back(16'hFFFF);
        pending_phases.push_back(16'h4321);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            load_gate_cfg(random_cfg());
            for (int n = 0; n < RAND_ITEMS; n++)
                pending_phases.push_back(pick_phase());
            if (ph == HOLD_PHASE) hold_request = 1'b1;
            wait_drained();
        end

        // Tail: full rate on both sides.
        idle_off = 1'b1;
        c = random_cfg();
        c.enable = 1'b1;
        load_gate_cfg(c);
        for (int n = 0; n < TAIL_ITEMS; n++)
            pending_phases.push_back(pick_phase());
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_gates.size() != 0)
            report_mismatch("results never arrived", 32'(expected_gates.size()), 32'(0));
        $display("Ran %0d register settings, %0d phase samples, %0d results checked",
                 cfg_phases, items_sent, results_seen);
        $display("Long output stall of %0d cycles applied, %0d mismatches", hold_count,
                 mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
hdl/erg_pkg.sv
hdl/erg_if.sv
hdl/erg_div_cell.sv
hdl/erg_scale.sv
hdl/euclidean_rhythm_gate_top.sv
tb/sv/euclidean_rhythm_gate_top_test.sv
